// ----- rtl/tkc_pkg.sv -----
package tkc_pkg;

    localparam int unsigned BYTE_W    = 8;
    localparam int unsigned CRC_W     = 16;
    localparam int unsigned KEY_W     = 24;
    localparam int unsigned POS_W     = 3;

    localparam logic [CRC_W-1:0]  CRC_POLY   = 16'h1021;
    localparam logic [CRC_W-1:0]  CRC_TOPBIT = 16'h8000;
    localparam logic [BYTE_W-1:0] HDR_BYTE0  = 8'd6;
    localparam logic [BYTE_W-1:0] HDR_BYTE1  = 8'd3;

    // frame slot codes
    localparam logic [POS_W-1:0] SLOT_HDR0   = 3'd0;
    localparam logic [POS_W-1:0] SLOT_HDR1   = 3'd1;
    localparam logic [POS_W-1:0] SLOT_KEY0   = 3'd2;
    localparam logic [POS_W-1:0] SLOT_KEY1   = 3'd3;
    localparam logic [POS_W-1:0] SLOT_KEY2   = 3'd4;
    localparam logic [POS_W-1:0] SLOT_CRC_LO = 3'd5;
    localparam logic [POS_W-1:0] SLOT_CRC_HI = 3'd6;

    typedef struct packed {
        logic [BYTE_W-1:0] rx_byte;
        logic              frame_start;
    } rx_req_t;

    typedef struct packed {
        logic [KEY_W-1:0] key_value;
        logic             crc_ok;
    } frame_res_t;

    // CRC-16, polynomial 0x1021, MSB first, one byte folded in
    function automatic logic [CRC_W-1:0] crc_feed(input logic [CRC_W-1:0]  crc,
                                                 input logic [BYTE_W-1:0] data);
        logic [CRC_W-1:0] c;
        c = crc ^ {data, {(CRC_W-BYTE_W){1'b0}}};
        for (int k = 0; k < BYTE_W; k++)
        begin
            if ((c & CRC_TOPBIT) != '0)
            begin
                c = {c[CRC_W-2:0], 1'b0} ^ CRC_POLY;
            end
            else
            begin
                c = {c[CRC_W-2:0], 1'b0};
            end
        end
        return c;
    endfunction

endpackage

// ----- rtl/tkc_in_reg.sv -----
module tkc_in_reg (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  tkc_pkg::rx_req_t in_req,
    input  logic             stage_go,
    output logic             stage_valid,
    output tkc_pkg::rx_req_t stage_req
);

    logic             valid_reg;
    logic             valid_next;
    tkc_pkg::rx_req_t req_reg;

    // take a new request when the stage is empty or moving on
    assign in_ready    = !valid_reg || stage_go;
    assign valid_next  = (in_valid && in_ready) || (valid_reg && !stage_go);
    assign stage_valid = valid_reg;
    assign stage_req   = req_reg;

    // hold the valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // capture the payload on accept
    always_ff @(posedge clk)
    begin
        if (in_valid && in_ready)
        begin
            req_reg <= in_req;
        end
    end

endmodule

// ----- rtl/tkc_frame_core.sv -----
module tkc_frame_core (
    input  logic                clk,
    input  logic                rst_n,
    input  tkc_pkg::rx_req_t    req,
    input  logic                fire,
    output logic                last_slot,
    output tkc_pkg::frame_res_t res
);

    logic [tkc_pkg::POS_W-1:0]  pos_reg,  pos_next;
    logic [tkc_pkg::CRC_W-1:0]  crc_reg,  crc_next;
    logic [tkc_pkg::KEY_W-1:0]  key_reg,  key_next;
    logic [tkc_pkg::BYTE_W-1:0] low_reg,  low_next;
    logic [tkc_pkg::POS_W-1:0]  slot;
    logic [tkc_pkg::CRC_W-1:0]  crc_fed;

    // pick the slot: restart forces slot 0, an unused position too
    always_comb
    begin
        if (req.frame_start || pos_reg > tkc_pkg::SLOT_CRC_HI)
        begin
            slot = tkc_pkg::SLOT_HDR0;
        end
        else
        begin
            slot = pos_reg;
        end
    end

    assign crc_fed   = tkc_pkg::crc_feed(crc_reg, req.rx_byte);
    assign last_slot = (slot == tkc_pkg::SLOT_CRC_HI);

    assign res.key_value = key_reg;
    assign res.crc_ok    = ({req.rx_byte, low_reg} == crc_reg);

    // advance the frame state for this byte
    always_comb
    begin
        crc_next = crc_reg;
        key_next = key_reg;
        low_next = low_reg;
        pos_next = last_slot ? tkc_pkg::SLOT_HDR0 : slot + 3'd1;
        case (slot)
            tkc_pkg::SLOT_HDR0:
            begin
                crc_next = tkc_pkg::crc_feed('0, tkc_pkg::HDR_BYTE0);
                key_next = '0;
                low_next = '0;
            end
            tkc_pkg::SLOT_HDR1:
            begin
                crc_next = tkc_pkg::crc_feed(crc_reg, tkc_pkg::HDR_BYTE1);
            end
            tkc_pkg::SLOT_KEY0:
            begin
                crc_next      = crc_fed;
                key_next[7:0] = req.rx_byte;
            end
            tkc_pkg::SLOT_KEY1:
            begin
                crc_next       = crc_fed;
                key_next[15:8] = req.rx_byte;
            end
            tkc_pkg::SLOT_KEY2:
            begin
                crc_next        = crc_fed;
                key_next[23:16] = req.rx_byte;
            end
            tkc_pkg::SLOT_CRC_LO:
            begin
                low_next = req.rx_byte;
            end
            default:
            begin
                // closing byte: result only, state wraps
            end
        endcase
    end

    // hold the frame state
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pos_reg <= '0;
            crc_reg <= '0;
            key_reg <= '0;
            low_reg <= '0;
        end
        else if (fire)
        begin
            pos_reg <= pos_next;
            crc_reg <= crc_next;
            key_reg <= key_next;
            low_reg <= low_next;
        end
    end

endmodule

// ----- rtl/tkc_out_reg.sv -----
module tkc_out_reg (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                load,
    input  tkc_pkg::frame_res_t load_res,
    output logic                free,
    output logic                out_valid,
    input  logic                out_ready,
    output tkc_pkg::frame_res_t out_res
);

    logic                valid_reg;
    logic                valid_next;
    tkc_pkg::frame_res_t res_reg;

    assign free       = !valid_reg || out_ready;
    assign valid_next = load || (valid_reg && !out_ready);
    assign out_valid  = valid_reg;
    assign out_res    = res_reg;

    // hold the result valid flag
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    // capture a finished frame result
    always_ff @(posedge clk)
    begin
        if (load)
        begin
            res_reg <= load_res;
        end
    end

endmodule

// ----- rtl/touch_key_frame_crc_checker.sv -----
// Channel  Direction  Handshake             Payload
// input    in         in_valid / in_ready   rx_byte[7:0], frame_start
// output   out        out_valid / out_ready key_value[23:0], crc_ok
//
// One byte per cycle is accepted while the input stage is not held; the request
// carrying the closing CRC byte passes the input register, then the result register.
// The byte-wide CRC update sits between the input register and the state.
// Reset clears the frame position, CRC, key bytes and both valid flags.
// A stalled result holds the input stage only when the next byte would close
// another frame; other bytes keep flowing.
module touch_key_frame_crc_checker (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [23:0] key_value,
    output logic        crc_ok
);

    tkc_pkg::rx_req_t    in_req;
    tkc_pkg::rx_req_t    stage_req;
    tkc_pkg::frame_res_t core_res;
    tkc_pkg::frame_res_t out_res;
    logic                stage_valid;
    logic                stage_go;
    logic                last_slot;
    logic                out_free;
    logic                res_load;

    assign in_req.rx_byte     = rx_byte;
    assign in_req.frame_start = frame_start;

    // advance the stage unless it would close a frame into a full result
    assign stage_go = stage_valid && (!last_slot || out_free);
    assign res_load = stage_go && last_slot;

    tkc_in_reg u_in_reg (
        .clk         (clk),
        .rst_n       (rst_n),
        .in_valid    (in_valid),
        .in_ready    (in_ready),
        .in_req      (in_req),
        .stage_go    (stage_go),
        .stage_valid (stage_valid),
        .stage_req   (stage_req)
    );

    tkc_frame_core u_frame_core (
        .clk       (clk),
        .rst_n     (rst_n),
        .req       (stage_req),
        .fire      (stage_go),
        .last_slot (last_slot),
        .res       (core_res)
    );

    tkc_out_reg u_out_reg (
        .clk       (clk),
        .rst_n     (rst_n),
        .load      (res_load),
        .load_res  (core_res),
        .free      (out_free),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_res   (out_res)
    );

    assign key_value = out_res.key_value;
    assign crc_ok    = out_res.crc_ok;

    // a closed frame always shows up as a pending result
    a_load_shows: assert property (@(posedge clk) disable iff (!rst_n)
        res_load |=> out_valid)
        else $error("closed frame did not raise out_valid");

    // a stalled stage keeps its byte
    a_stage_holds: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !stage_go |=> stage_valid && $stable(stage_req))
        else $error("stalled input stage lost its byte");

    // the stage only waits behind an unread result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        stage_valid && !stage_go |-> out_valid && !out_ready)
        else $error("input stage stalled without a blocked result");

endmodule

// ----- tb/tkc_tb_pkg.sv -----
`timescale 1ns / 1ps

package tkc_tb_pkg;

    // Fold one byte into a CRC-16 (poly 0x1021), MSB first, one bit at a time
    function automatic logic [15:0] crc16_ccitt_byte(input logic [15:0] crc,
                                                     input logic [7:0]  data);
        logic [15:0] acc;
        logic        fb;
        acc = crc;
        for (int i = 7; i >= 0; i--)
        begin
            fb  = acc[15] ^ data[i];
            acc = {acc[14:0], 1'b0} ^ (fb ? tkc_pkg::CRC_POLY : 16'h0000);
        end
        return acc;
    endfunction

endpackage

// ----- tb/key_frame_monitor.sv -----
`timescale 1ns / 1ps

module key_frame_monitor (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    input  logic        in_ready,
    input  logic [7:0]  rx_byte,
    input  logic        frame_start,
    input  logic        out_valid,
    input  logic        out_ready,
    input  logic [23:0] key_value,
    input  logic        crc_ok,
    output int          err_count,
    output int          frames_due_count,
    output int          frames_checked,
    output int          frames_crc_good
);

    // Track the frame, following the slot walk of the checker
    logic [tkc_pkg::POS_W-1:0]  slot_q;
    logic [tkc_pkg::CRC_W-1:0]  crc_q;
    logic [tkc_pkg::KEY_W-1:0]  keys_q;
    logic [tkc_pkg::BYTE_W-1:0] crc_lo_q;

    tkc_pkg::frame_res_t frames_due[$];
    tkc_pkg::frame_res_t oldest_frame;

    // Advance the frame by one accepted request; queue a result on the closing byte
    task automatic fold_rx_byte(input logic [tkc_pkg::BYTE_W-1:0] b, input logic fs);
        logic [tkc_pkg::POS_W-1:0] slot;
        logic [tkc_pkg::KEY_W-1:0] wide_b;
        tkc_pkg::frame_res_t       res;
        wide_b = {{(tkc_pkg::KEY_W-tkc_pkg::BYTE_W){1'b0}}, b};
        slot   = fs ? tkc_pkg::SLOT_HDR0 : slot_q;
        if (slot > tkc_pkg::SLOT_CRC_HI)
        begin
            slot = tkc_pkg::SLOT_HDR0;
        end
        case (slot)
            tkc_pkg::SLOT_HDR0:
            begin
                // header bytes on the wire are ignored, fixed values go into the CRC
                crc_q    = tkc_tb_pkg::crc16_ccitt_byte('0, tkc_pkg::HDR_BYTE0);
                keys_q   = '0;
                crc_lo_q = '0;
            end
            tkc_pkg::SLOT_HDR1:
            begin
                crc_q = tkc_tb_pkg::crc16_ccitt_byte(crc_q, tkc_pkg::HDR_BYTE1);
            end
            tkc_pkg::SLOT_KEY0, tkc_pkg::SLOT_KEY1, tkc_pkg::SLOT_KEY2:
            begin
                crc_q  = tkc_tb_pkg::crc16_ccitt_byte(crc_q, b);
                keys_q = keys_q | (wide_b << (8 * (slot - tkc_pkg::SLOT_KEY0)));
            end
            tkc_pkg::SLOT_CRC_LO:
            begin
                crc_lo_q = b;
            end
            tkc_pkg::SLOT_CRC_HI:
            begin
                // received CRC is little-endian
                res.key_value = keys_q;
                res.crc_ok    = ({b, crc_lo_q} == crc_q);
                frames_due.push_back(res);
            end
            default:
            begin
            end
        endcase
        slot_q = (slot >= tkc_pkg::SLOT_CRC_HI) ? tkc_pkg::SLOT_HDR0 : slot + 1'b1;
    endtask

    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            slot_q          = tkc_pkg::SLOT_HDR0;
            crc_q           = '0;
            keys_q          = '0;
            crc_lo_q        = '0;
            err_count       = 0;
            frames_checked  = 0;
            frames_crc_good = 0;
            frames_due.delete();
        end
        else
        begin
            // Compare an accepted result with the oldest frame due
            if (out_valid && out_ready)
            begin
                if (frames_due.size() == 0)
                begin
                    $display("%0t: result with no frame due, key_value=%06h crc_ok=%0b",
                             $time, key_value, crc_ok);
                    err_count++;
                end
                else
                begin
                    oldest_frame = frames_due.pop_front();
                    frames_checked++;
                    if (oldest_frame.crc_ok)
                    begin
                        frames_crc_good++;
                    end
                    if (key_value !== oldest_frame.key_value)
                    begin
                        $display("%0t: key_value mismatch, expected %06h, actual %06h",
                                 $time, oldest_frame.key_value, key_value);
                        err_count++;
                    end
                    if (crc_ok !== oldest_frame.crc_ok)
                    begin
                        $display("%0t: crc_ok mismatch, expected %0b, actual %0b",
                                 $time, oldest_frame.crc_ok, crc_ok);
                        err_count++;
                    end
                end
            end
            // Track each accepted request
            if (in_valid && in_ready)
            begin
                fold_rx_byte(rx_byte, frame_start);
            end
        end
        frames_due_count = frames_due.size();
    end

endmodule

// ----- tb/touch_key_frame_crc_checker_tb.sv -----
`timescale 1ns / 1ps

module touch_key_frame_crc_checker_tb;

    localparam int CLK_PERIOD   = 10;
    localparam int TOTAL_BYTES  = 425;
    localparam int CALM_AFTER   = 355;
    localparam int DRAIN_CYCLES = 8;
    localparam int CYCLE_LIMIT  = 200000;

    logic        clk = 1'b0;
    logic        rst_n;
    logic        in_valid;
    logic        in_ready;
    logic [7:0]  rx_byte;
    logic        frame_start;
    logic        out_valid;
    logic        out_ready;
    logic [23:0] key_value;
    logic        crc_ok;

    int err_count;
    int frames_due_count;
    int frames_checked;
    int frames_crc_good;
    int bytes_sent  = 0;
    int cycle_count = 0;
    bit calm        = 1'b0;
    bit need_start  = 1'b0;

    touch_key_frame_crc_checker u_top (
        .clk        (clk),
        .rst_n      (rst_n),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .rx_byte    (rx_byte),
        .frame_start(frame_start),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .key_value  (key_value),
        .crc_ok     (crc_ok)
    );

    key_frame_monitor u_mon (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_ready        (in_ready),
        .rx_byte         (rx_byte),
        .frame_start     (frame_start),
        .out_valid       (out_valid),
        .out_ready       (out_ready),
        .key_value       (key_value),
        .crc_ok          (crc_ok),
        .err_count       (err_count),
        .frames_due_count(frames_due_count),
        .frames_checked  (frames_checked),
        .frames_crc_good (frames_crc_good)
    );

    always #(CLK_PERIOD / 2) clk = ~clk;

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("touch_key_frame_crc_checker regression: fail");
            $finish;
        end
    end

    // Stall the result side in random bursts until the closing stretch
    initial
    begin
        out_ready = 1'b1;
        forever
        begin
            @(negedge clk);
            if (!calm && $urandom_range(0, 5) == 0)
            begin
                out_ready <= 1'b0;
                repeat ($urandom_range(1, 12)) @(negedge clk);
                out_ready <= 1'b1;
            end
        end
    end

    // Offer one request, with an optional idle burst ahead of it
    task automatic push_byte(input logic [7:0] b, input logic fs);
        int gap;
        if (!calm && $urandom_range(0, 4) == 0)
        begin
            gap = $urandom_range(1, 12);
            @(negedge clk);
            in_valid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
        @(negedge clk);
        in_valid    <= 1'b1;
        rx_byte     <= b;
        frame_start <= fs;
        do
            @(posedge clk);
        while (!in_ready);
        bytes_sent++;
    endtask

    // Send a whole seven-byte reply; optionally spoil its CRC
    task automatic send_frame(input logic [23:0] keys, input logic fs_first,
                              input bit corrupt);
        logic [15:0] crc;
        logic [15:0] flip;
        crc = tkc_tb_pkg::crc16_ccitt_byte(16'h0000, tkc_pkg::HDR_BYTE0);
        crc = tkc_tb_pkg::crc16_ccitt_byte(crc, tkc_pkg::HDR_BYTE1);
        for (int i = 0; i < 3; i++)
        begin
            crc = tkc_tb_pkg::crc16_ccitt_byte(crc, keys[8*i +: 8]);
        end
        if (corrupt)
        begin
            // single bit flip or a random nonzero pattern
            flip = 16'($urandom_range(1, 16'hFFFF));
            if ($urandom_range(0, 1) == 1)
            begin
                flip = 16'h0001 << $urandom_range(0, 15);
            end
            crc = crc ^ flip;
        end
        push_byte(8'($urandom_range(0, 255)), fs_first);
        push_byte(8'($urandom_range(0, 255)), 1'b0);
        for (int i = 0; i < 3; i++)
        begin
            push_byte(keys[8*i +: 8], 1'b0);
        end
        push_byte(crc[7:0], 1'b0);
        push_byte(crc[15:8], 1'b0);
    endtask

    // Random bytes with scattered frame starts; leave the frame position unknown
    task automatic send_noise();
        int n;
        n = $urandom_range(1, 6);
        repeat (n)
        begin
            push_byte(8'($urandom_range(0, 255)), $urandom_range(0, 3) == 0);
        end
        need_start = 1'b1;
    endtask

    initial
    begin
        int          pick;
        logic [23:0] keys;

        rst_n       = 1'b0;
        in_valid    = 1'b0;
        rx_byte     = '0;
        frame_start = 1'b0;
        repeat (9) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: first frame straight after reset with no start mark, all-zero keys
        send_frame(24'h000000, 1'b0, 1'b0);
        // Abandon a partial frame, then restart with all-ones keys
        push_byte(8'hFF, 1'b1);
        push_byte(8'h00, 1'b0);
        push_byte(8'hFF, 1'b0);
        send_frame(24'hFFFFFF, 1'b1, 1'b0);
        // Back-to-back frame without a start mark and a bad CRC
        send_frame(24'hA55A3C, 1'b0, 1'b1);

        // Random: mostly well-formed replies, some noise and bad CRCs
        while (bytes_sent < TOTAL_BYTES)
        begin
            if (bytes_sent > CALM_AFTER)
            begin
                calm = 1'b1;
            end
            pick = $urandom_range(0, 9);
            if (pick == 0)
            begin
                send_noise();
            end
            else
            begin
                case ($urandom_range(0, 7))
                    0:       keys = 24'h000000;
                    1:       keys = 24'hFFFFFF;
                    default: keys = 24'($urandom);
                endcase
                send_frame(keys, need_start || ($urandom_range(0, 1) == 1),
                           $urandom_range(0, 4) == 0);
                need_start = 1'b0;
            end
        end
        @(negedge clk);
        in_valid <= 1'b0;

        // Drain outstanding results, then let the pipeline settle
        while (frames_due_count != 0)
        begin
            @(negedge clk);
        end
        repeat (DRAIN_CYCLES) @(negedge clk);

        $display("Drove %0d bytes with random stalls on both sides; %0d frames checked,",
                 bytes_sent, frames_checked);
        $display("%0d with a matching CRC, the rest with a damaged or random CRC.",
                 frames_crc_good);
        if (err_count == 0)
        begin
            $display("touch_key_frame_crc_checker regression: pass");
        end
        else
        begin
            $display("touch_key_frame_crc_checker regression: fail");
        end
        $finish;
    end

endmodule
